@@ src/assert_macros.svh @@
// assertion helpers shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/crcdg_pkg.sv @@
// shared types and constants for the crc divider
// no dependencies
package crcdg_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DEG_W      = 6;
    localparam int OUT_W      = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;

    // reset values
    localparam logic [CFG_DATA_W-1:0] POLY_RESET   = 32'h0000_1021;
    localparam logic [DEG_W-1:0]      DEGREE_RESET = 6'd16;

    // division mode
    localparam logic MODE_GENERATE = 1'b0;
    localparam logic MODE_CHECK    = 1'b1;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] poly;
        logic [DEG_W-1:0]      degree;  // effective degree, 1..cap
        logic                  mode;
    } cfg_t;

endpackage

@@ src/crcdg_cfg.sv @@
// configuration registers and effective degree clamp
// depends on crcdg_pkg
module crcdg_cfg #(
    parameter int DEG_CAP = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [crcdg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [crcdg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output crcdg_pkg::cfg_t                   cfg
);
    import crcdg_pkg::*;

    localparam logic [DEG_W-1:0] CAP = DEG_W'(DEG_CAP);

    logic [CFG_DATA_W-1:0] poly_reg;
    logic [DEG_W-1:0]      degree_reg;
    logic                  mode_reg;
    logic [DEG_W-1:0]      degree_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg   <= POLY_RESET;
            degree_reg <= DEGREE_RESET;
            mode_reg   <= MODE_GENERATE;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_POLY_LOW: poly_reg   <= cfg_wdata;
                CFG_DEGREE:   degree_reg <= cfg_wdata[DEG_W-1:0];
                CFG_MODE:     mode_reg   <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    // degree zero acts as one, large degrees saturate at the cap
    always_comb begin
        if (degree_reg == '0) begin
            degree_eff = DEG_W'(1);
        end else if (degree_reg > CAP) begin
            degree_eff = CAP;
        end else begin
            degree_eff = degree_reg;
        end
    end

    assign cfg.poly   = poly_reg;
    assign cfg.degree = degree_eff;
    assign cfg.mode   = mode_reg;

endmodule

@@ src/crcdg_rem.sv @@
// running remainder register and one-bit gf(2) division step
// depends on crcdg_pkg
module crcdg_rem #(
    parameter int REM_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  crcdg_pkg::cfg_t   cfg,
    input  logic              step_en,
    input  logic              data_bit,
    input  logic              last_bit,
    output logic [REM_W-1:0]  rem_step,
    output logic [REM_W-1:0]  rem_cur
);
    import crcdg_pkg::*;

    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic [REM_W-1:0] mask;
    logic [REM_W-1:0] top_sel;
    logic [REM_W-1:0] rem_m;
    logic [REM_W-1:0] poly_m;
    logic [REM_W-1:0] shifted;
    logic             top;
    logic             fb;

    always_comb begin
        for (int i = 0; i < REM_W; i++) begin
            mask[i]    = (DEG_W'(i) < cfg.degree);
            top_sel[i] = (DEG_W'(i + 1) == cfg.degree);
        end
    end

    assign rem_m  = rem_reg & mask;
    assign poly_m = REM_W'(cfg.poly) & mask;
    assign top    = |(rem_m & top_sel);

    always_comb begin
        if (cfg.mode == MODE_CHECK) begin
            // plain division: bit shifts in at the bottom
            shifted = ((rem_m << 1) | REM_W'(data_bit)) & mask;
            fb      = top;
        end else begin
            // augmented division: bit folds in at the top
            shifted = (rem_m << 1) & mask;
            fb      = top ^ data_bit;
        end
        rem_step = fb ? (shifted ^ poly_m) : shifted;
    end

    always_comb begin
        rem_next = rem_reg;
        if (step_en) begin
            rem_next = last_bit ? '0 : rem_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    assign rem_cur = rem_reg;

endmodule

@@ src/crc_divide_generate_check.sv @@
// top level of the configurable bit-serial crc divider
// depends on crcdg_pkg, crcdg_cfg, crcdg_rem and assert_macros.svh
//
// usage:
//   input stream: one dividend bit per transfer in s_tdata[0], most significant
//   first; s_tlast marks the final bit of a message.
//   output stream: one transfer per message, given for the bit marked last.
//   m_tdata carries the final remainder (low degree bits, upper bits zero),
//   m_tuser is set when that remainder is nonzero (an error in check mode).
//   config: cfg_we writes cfg_wdata to register cfg_index (0 poly low bits,
//   1 degree, 2 check mode); only while the stream is idle.
// timing:
//   one bit per cycle while s_tready is high; each bit does a single shift and conditional xor of
//   the remainder register. the result appears in the output register in the
//   cycle after the last bit is taken.
//   s_tready is high while the output register is empty or being emptied,
//   so a stalled receiver holds the input off only while a result waits.
// reset:
//   aresetn low clears the remainder and the output valid flag, and loads the
//   default generator (x^16 + 0x1021, generate mode).
module crc_divide_generate_check #(
    parameter int MAX_DEGREE = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [0] data_bit
    input  logic                             s_tlast,   // last_bit
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [crcdg_pkg::OUT_W-1:0]      m_tdata,   // [31:0] remainder_value
    output logic [0:0]                       m_tuser,   // [0] remainder_nonzero
    // config write port
    input  logic                             cfg_we,
    input  logic [crcdg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crcdg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import crcdg_pkg::*;

    `include "assert_macros.svh"

    localparam int DEG_CAP = (MAX_DEGREE < 32) ? MAX_DEGREE : 32;
    localparam int REM_W   = DEG_CAP;

    cfg_t             cfg;
    logic             in_fire;
    logic [REM_W-1:0] rem_step;
    logic [REM_W-1:0] rem_cur;

    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    crcdg_cfg #(
        .DEG_CAP (DEG_CAP)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    crcdg_rem #(
        .REM_W (REM_W)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .step_en  (in_fire),
        .data_bit (s_tdata[0]),
        .last_bit (s_tlast),
        .rem_step (rem_step),
        .rem_cur  (rem_cur)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (in_fire && s_tlast) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload, loaded on the transfer of the last bit
    always_ff @(posedge aclk) begin
        if (in_fire && s_tlast) begin
            m_tdata_reg <= OUT_W'(rem_step);
            m_tuser_reg <= |rem_step;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    `ASSERT_SAME(a_result_from_last, aclk, aresetn, $rose(m_tvalid),
        $past(s_tvalid && s_tready && s_tlast), "result without a last bit")
    `ASSERT_NEXT(a_rem_clears, aclk, aresetn, in_fire && s_tlast,
        rem_cur == '0, "remainder not cleared after last bit")
    `ASSERT_SAME(a_flag_matches, aclk, aresetn, m_tvalid,
        m_tuser[0] == (m_tdata != '0), "nonzero flag disagrees with remainder")
    `ASSERT_SAME(a_degree_range, aclk, aresetn, 1'b1,
        (cfg.degree != '0) && (cfg.degree <= DEG_W'(DEG_CAP)), "degree out of range")

endmodule
